[hdl/ple_pkg.sv]
// Shared types and constants for the positional list engine.
package ple_pkg;

    localparam int CAPACITY      = 64;
    localparam int ELEMENT_WIDTH = 32;
    localparam int IDX_W         = $clog2(CAPACITY);
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int POS_W         = 7;
    localparam int OPC_W         = 3;
    localparam int STAT_W        = 2;

    localparam logic [OPC_W-1:0] OP_INSERT     = 3'd0;
    localparam logic [OPC_W-1:0] OP_REMOVE     = 3'd1;
    localparam logic [OPC_W-1:0] OP_READ       = 3'd2;
    localparam logic [OPC_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OPC_W-1:0] OP_PEEK_FIRST = 3'd4;
    localparam logic [OPC_W-1:0] OP_PEEK_LAST  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [OPC_W-1:0]         opcode;
        logic [POS_W-1:0]         position;
        logic [ELEMENT_WIDTH-1:0] element;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [ELEMENT_WIDTH-1:0] element_out;
        logic [CNT_W-1:0]         count_out;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_DONE
    } t_state;

endpackage

[hdl/positional_list_engine_top.sv]
// Top level of the positional list engine: list store, sequencer and result register.

// Bounded ordered list of up to CAPACITY element handles, held contiguously in
// one single-port-write, registered-read memory. One transaction in gives one
// result out. Reads and peeks pass through S_READ and S_DRAIN; an insert inside
// the list, a remove or a pop walks in S_SHIFT, because every entry behind the
// position is moved through the memory one entry per cycle (read, then write
// back one slot over). A new transaction is taken only once the previous one
// has left the sequencer; a finished result may wait in the output register
// meanwhile. No clearing pass is needed after reset: only entries below the
// count are ever read.
module positional_list_engine_top
    import ple_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // list store
    logic [ELEMENT_WIDTH-1:0] r_mem [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] r_rd_data;

    t_state r_state, n_state;

    logic [OPC_W-1:0]         r_op;
    logic [ELEMENT_WIDTH-1:0] r_elem;
    logic [ELEMENT_WIDTH-1:0] r_val;
    logic [STAT_W-1:0]        r_status;
    logic [CNT_W-1:0]         r_count;
    logic [IDX_W-1:0]         r_idx;
    logic [IDX_W-1:0]         r_ptr;
    logic [IDX_W-1:0]         r_stop;
    logic                     r_pend;
    logic                     r_pend_cap;
    logic [IDX_W-1:0]         r_pend_addr;
    logic                     r_out_valid;
    t_out_item                r_out_data;

    logic                     w_accept;
    logic                     w_out_free;
    logic [CNT_W-1:0]         w_cnt_m1;
    logic                     w_pos_end;
    logic [IDX_W-1:0]         w_pos_idx;
    logic [IDX_W-1:0]         w_last_idx;
    logic [STAT_W-1:0]        w_dec_status;
    logic [IDX_W-1:0]         w_dec_idx;
    logic [IDX_W-1:0]         w_dec_ptr;
    logic [IDX_W-1:0]         w_dec_stop;
    logic                     w_we;
    logic [IDX_W-1:0]         w_wa;
    logic [ELEMENT_WIDTH-1:0] w_wd;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cnt_m1   = r_count - CNT_W'(1);
    assign w_last_idx = w_cnt_m1[IDX_W-1:0];
    assign w_pos_end  = (i_in_data.position >= POS_W'(r_count));
    assign w_pos_idx  = i_in_data.position[IDX_W-1:0];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // decode, next state and memory write selection
    always_comb begin
        n_state      = r_state;
        w_dec_status = ST_MISSING;
        w_dec_idx    = '0;
        w_dec_ptr    = '0;
        w_dec_stop   = '0;
        w_we         = r_pend && !r_pend_cap;
        w_wa         = r_pend_addr;
        w_wd         = r_rd_data;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DONE;
                    case (i_in_data.opcode)
                        OP_INSERT: begin
                            if (r_count >= CAP_CNT) begin
                                w_dec_status = ST_FULL;
                            end else begin
                                w_dec_status = ST_OK;
                                w_dec_idx    = w_pos_end ? r_count[IDX_W-1:0] : w_pos_idx;
                                w_dec_ptr    = w_last_idx;
                                w_dec_stop   = w_dec_idx;
                                n_state      = w_pos_end ? S_PUT : S_SHIFT;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_count != '0) begin
                                w_dec_status = ST_OK;
                                w_dec_idx    = (w_pos_end || r_count == CNT_W'(1)) ?
                                               w_last_idx : w_pos_idx;
                                w_dec_ptr    = w_dec_idx;
                                w_dec_stop   = w_last_idx;
                                n_state      = S_SHIFT;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (r_count != '0) begin
                                w_dec_status = ST_OK;
                                w_dec_stop   = w_last_idx;
                                n_state      = S_SHIFT;
                            end
                        end
                        OP_READ: begin
                            if (!w_pos_end) begin
                                w_dec_status = ST_OK;
                                w_dec_ptr    = w_pos_idx;
                                n_state      = S_READ;
                            end
                        end
                        OP_PEEK_FIRST: begin
                            if (r_count != '0) begin
                                w_dec_status = ST_OK;
                                n_state      = S_READ;
                            end
                        end
                        OP_PEEK_LAST: begin
                            if (r_count != '0) begin
                                w_dec_status = ST_OK;
                                w_dec_ptr    = w_last_idx;
                                n_state      = S_READ;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_DRAIN;
            end
            S_SHIFT: begin
                if (r_ptr == r_stop) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = (r_op == OP_INSERT) ? S_PUT : S_DONE;
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_wa    = r_idx;
                w_wd    = r_elem;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory: one write port, registered read at the walk pointer
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_mem[r_ptr];
    end

    // transaction registers and walk pointer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_in_data.opcode;
            r_elem   <= i_in_data.element;
            r_status <= w_dec_status;
            r_idx    <= w_dec_idx;
            r_ptr    <= w_dec_ptr;
            r_stop   <= w_dec_stop;
            r_val    <= '0;
        end else begin
            // capture the element that was read or removed
            if (r_pend && r_pend_cap) begin
                r_val <= r_rd_data;
            end
            // advance the walk: down for insert, up for remove and pop
            if (r_state == S_SHIFT) begin
                if (r_op == OP_INSERT) begin
                    r_pend_addr <= r_ptr + IDX_W'(1);
                    r_ptr       <= r_ptr - IDX_W'(1);
                end else begin
                    r_pend_addr <= r_ptr - IDX_W'(1);
                    r_ptr       <= r_ptr + IDX_W'(1);
                end
            end
        end
    end

    // pending read tracking and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= 1'b0;
            r_pend_cap <= 1'b0;
            r_count    <= '0;
        end else begin
            case (r_state)
                S_READ: begin
                    r_pend     <= 1'b1;
                    r_pend_cap <= 1'b1;
                end
                S_SHIFT: begin
                    r_pend     <= 1'b1;
                    r_pend_cap <= (r_op != OP_INSERT) && (r_ptr == r_idx);
                end
                default: begin
                    r_pend     <= 1'b0;
                    r_pend_cap <= 1'b0;
                end
            endcase
            if (r_state == S_PUT) begin
                r_count <= r_count + CNT_W'(1);
            end else if (r_state == S_DRAIN &&
                         (r_op == OP_REMOVE || r_op == OP_POP_FRONT)) begin
                r_count <= w_cnt_m1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_data.status      <= r_status;
            r_out_data.element_out <= r_val;
            r_out_data.count_out   <= r_count;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("element count above capacity");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.element_out == '0)
        else $error("failed result carries an element");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_FULL |-> o_out_data.count_out == CAP_CNT)
        else $error("full status with list not full");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("transaction accepted while sequencer still busy");
`endif

endmodule
